// ----- design/length_framed_packet_crc_checker_core_macros.svh -----
`ifndef LENGTH_FRAMED_PACKET_CRC_CHECKER_CORE_MACROS_SVH
`define LENGTH_FRAMED_PACKET_CRC_CHECKER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define LFPC_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfpc assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define LFPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfpc assertion failed");

`endif

// ----- design/lfpc_pkg.sv -----
package lfpc_pkg;

    localparam logic [15:0] CRC_INIT       = 16'h1D0F;
    localparam logic [15:0] CRC_XOROUT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [16:0] LONG_OVERHEAD  = 17'd5;
    localparam logic [16:0] SHORT_OVERHEAD = 17'd3;
    localparam logic [16:0] LONG_HEADER    = 17'd3;
    localparam logic [16:0] SHORT_HEADER   = 17'd1;
    localparam logic [15:0] LIMIT_RESET    = 16'd1024;
    localparam int          FIFO_DEPTH     = 4;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_CRC  = 2'd1;
    localparam logic [1:0] STATUS_FAIL = 2'd2;

    typedef struct packed {
        logic        is_end;
        logic [7:0]  data;
        logic [1:0]  status;
        logic [15:0] length;
    } lfpc_item_t;

    typedef struct packed {
        logic [1:0] n;
        lfpc_item_t first;
        lfpc_item_t second;
    } lfpc_push_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- design/length_framed_packet_crc_checker_core.sv -----
// Channel  Direction  Handshake             Fields
// in       input      in_valid / in_ready   rx_byte, abort
// out      output     out_valid / out_ready is_end, payload_byte, status, payload_length
// config   input      buffer_limit_we       buffer_limit
//
// One byte per cycle while the output queue has room: a held input byte is processed
// (byte-wide CRC step, length compare) and its results land in the output queue.
// An overflowing payload byte yields two results, so the output side sets the long-run rate.
// A result is shown once its byte has left the hold register and been written to the queue.
// rst_n clears packet state, buffer_limit to 1024, and empties the output queue.
// A stalled output holds the input side off once the queue has fewer than two free entries.
module length_framed_packet_crc_checker_core
    import lfpc_pkg::*;
#(
    parameter int OUT_DEPTH = FIFO_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        abort,
    input  logic        buffer_limit_we,
    input  logic [15:0] buffer_limit,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        is_end,
    output logic [7:0]  payload_byte,
    output logic [1:0]  status,
    output logic [15:0] payload_length
);

    logic       room;
    logic       push_valid;
    lfpc_push_t push;

    lfpc_deframer u_deframer (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .abort           (abort),
        .buffer_limit_we (buffer_limit_we),
        .buffer_limit    (buffer_limit),
        .room            (room),
        .push_valid      (push_valid),
        .push            (push)
    );

    lfpc_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk            (clk),
        .rst_n          (rst_n),
        .push_valid     (push_valid),
        .push           (push),
        .room           (room),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .is_end         (is_end),
        .payload_byte   (payload_byte),
        .status         (status),
        .payload_length (payload_length)
    );

endmodule

// ----- design/lfpc_deframer.sv -----
`include "length_framed_packet_crc_checker_core_macros.svh"

module lfpc_deframer
    import lfpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        abort,
    input  logic        buffer_limit_we,
    input  logic [15:0] buffer_limit,
    input  logic        room,
    output logic        push_valid,
    output lfpc_push_t  push
);

    logic        hold_valid_reg, hold_valid_next;
    logic [7:0]  hold_byte_reg;
    logic        hold_abort_reg;
    logic [15:0] limit_reg;

    logic [15:0] count_reg, count_next;
    logic        long_reg, long_next;
    logic        known_reg, known_next;
    logic [15:0] decl_reg, decl_next;
    logic [7:0]  high_reg, high_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  rxh_reg, rxh_next;

    logic        step_fire;
    logic        accept;
    logic        pay_v, end_v, just;
    logic [1:0]  end_status;
    logic [15:0] end_len;
    logic [16:0] idx17, count17, hdr_end, total;
    logic [15:0] crc_fed;
    lfpc_item_t  pay_item, end_item;

    assign step_fire = hold_valid_reg && room;
    assign in_ready  = !hold_valid_reg || step_fire;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (step_fire)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            limit_reg      <= LIMIT_RESET;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            if (buffer_limit_we)
            begin
                limit_reg <= buffer_limit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_byte_reg  <= rx_byte;
            hold_abort_reg <= abort;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        long_next  = long_reg;
        known_next = known_reg;
        decl_next  = decl_reg;
        high_next  = high_reg;
        crc_next   = crc_reg;
        rxh_next   = rxh_reg;
        pay_v      = 1'b0;
        end_v      = 1'b0;
        just       = 1'b0;
        end_status = STATUS_OK;
        end_len    = 16'd0;
        idx17      = {1'b0, count_reg};
        count17    = idx17 + 17'd1;
        hdr_end    = {1'b0, decl_reg} + (long_reg ? LONG_HEADER : SHORT_HEADER);
        crc_fed    = crc_byte(crc_reg, hold_byte_reg);
        total      = 17'd0;

        if (hold_abort_reg)
        begin
            if (count_reg != 16'd0)
            begin
                end_v      = 1'b1;
                end_status = STATUS_FAIL;
            end
        end
        else
        begin
            if (count_reg == 16'd0)
            begin
                crc_next = crc_fed;
                if (hold_byte_reg != 8'd0)
                begin
                    decl_next  = {8'd0, hold_byte_reg};
                    known_next = 1'b1;
                    just       = 1'b1;
                end
                else
                begin
                    long_next = 1'b1;
                end
            end
            else if (long_reg && count_reg == 16'd1)
            begin
                crc_next  = crc_fed;
                high_next = hold_byte_reg;
            end
            else if (long_reg && count_reg == 16'd2)
            begin
                crc_next   = crc_fed;
                decl_next  = {high_reg, hold_byte_reg};
                known_next = 1'b1;
                just       = 1'b1;
            end
            else if (idx17 < hdr_end)
            begin
                crc_next = crc_fed;
                pay_v    = 1'b1;
            end
            else if (idx17 == hdr_end)
            begin
                rxh_next = hold_byte_reg;
            end

            total = {1'b0, decl_next} + (long_next ? LONG_OVERHEAD : SHORT_OVERHEAD);

            if (known_next && count17 >= total)
            begin
                end_v = 1'b1;
                if ((crc_next ^ CRC_XOROUT) == {rxh_next, hold_byte_reg})
                begin
                    end_status = STATUS_OK;
                    end_len    = decl_next;
                end
                else
                begin
                    end_status = STATUS_CRC;
                end
            end
            else if (count17 >= {1'b0, limit_reg} || (just && {1'b0, limit_reg} < total))
            begin
                end_v      = 1'b1;
                end_status = STATUS_FAIL;
            end
            else
            begin
                count_next = count17[15:0];
            end
        end

        if (end_v)
        begin
            count_next = 16'd0;
            long_next  = 1'b0;
            known_next = 1'b0;
            decl_next  = 16'd0;
            high_next  = 8'd0;
            crc_next   = CRC_INIT;
            rxh_next   = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 16'd0;
            long_reg  <= 1'b0;
            known_reg <= 1'b0;
            decl_reg  <= 16'd0;
            high_reg  <= 8'd0;
            crc_reg   <= CRC_INIT;
            rxh_reg   <= 8'd0;
        end
        else if (step_fire)
        begin
            count_reg <= count_next;
            long_reg  <= long_next;
            known_reg <= known_next;
            decl_reg  <= decl_next;
            high_reg  <= high_next;
            crc_reg   <= crc_next;
            rxh_reg   <= rxh_next;
        end
    end

    always_comb
    begin
        pay_item        = '0;
        pay_item.data   = hold_byte_reg;
        end_item        = '0;
        end_item.is_end = 1'b1;
        end_item.status = end_status;
        end_item.length = end_len;
        push_valid      = step_fire;
        push.n          = {1'b0, pay_v} + {1'b0, end_v};
        push.first      = pay_v ? pay_item : end_item;
        push.second     = end_item;
    end

    `LFPC_ASSERT(a_pair_is_fail, step_fire && pay_v && end_v, end_status == STATUS_FAIL)
    `LFPC_ASSERT_NEXT(a_clear_after_end, step_fire && end_v, count_reg == 16'd0 && !known_reg)
    `LFPC_ASSERT(a_idle_state_clean, count_reg == 16'd0, crc_reg == CRC_INIT && !long_reg)

endmodule

// ----- design/lfpc_out_fifo.sv -----
`include "length_framed_packet_crc_checker_core_macros.svh"

module lfpc_out_fifo
    import lfpc_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    input  lfpc_push_t  push,
    output logic        room,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        is_end,
    output logic [7:0]  payload_byte,
    output logic [1:0]  status,
    output logic [15:0] payload_length
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] ROOM_MAX  = CW'(DEPTH - 2);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);
    localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);

    lfpc_item_t mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] wr_ptr_p1;
    logic [1:0]    push_n;
    logic          pop;
    lfpc_item_t    head;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == LAST_PTR) ? '0 : p + PW'(1);
    endfunction

    assign push_n    = push_valid ? push.n : 2'd0;
    assign pop       = out_valid && out_ready;
    assign out_valid = count_reg != '0;
    assign room      = count_reg <= ROOM_MAX;
    assign wr_ptr_p1 = bump(wr_ptr_reg);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        case (push_n)
            2'd1: wr_ptr_next = wr_ptr_p1;
            2'd2: wr_ptr_next = bump(wr_ptr_p1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(push_n) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push_n == 2'd2)
        begin
            mem[wr_ptr_p1] <= push.second;
        end
    end

    assign head           = mem[rd_ptr_reg];
    assign is_end         = head.is_end;
    assign payload_byte   = head.data;
    assign status         = head.status;
    assign payload_length = head.length;

    `LFPC_ASSERT(a_no_overrun, push_n != 2'd0, count_reg <= ROOM_MAX)
    `LFPC_ASSERT(a_count_bound, 1'b1, count_reg <= DEPTH_CNT)

endmodule
